>>> hdl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ABRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ABRA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/abra_pkg.sv
// Shared types, codes and helper functions of the aligned byte region allocator.
package abra_pkg;

    // Run lengths reach the full region (at most 256 bytes).
    localparam int RUN_W = 9;

    localparam logic [1:0] OP_BEST = 2'd0;
    localparam logic [1:0] OP_AT   = 2'd1;
    localparam logic [1:0] OP_INIT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;
    localparam logic [1:0] ST_NOSPACE = 2'd3;

    localparam logic REG_WIN_START = 1'b0;
    localparam logic REG_WIN_LEN   = 1'b1;

    typedef struct packed {
        logic [RUN_W-1:0] rl_prev;
        logic             free;
        logic [7:0]       size;
        logic [7:0]       align;
    } t_calc_in;

    typedef struct packed {
        logic [RUN_W-1:0] rl_next;
        logic             fits;
        logic [7:0]       score;
    } t_calc_res;

    // Largest power of two not above x; zero for zero.
    function automatic logic [RUN_W-1:0] msb_pow2(input logic [RUN_W-1:0] x);
        logic [RUN_W-1:0] r;
        r = '0;
        for (int i = 0; i < RUN_W; i++) begin
            if (x[i]) begin
                r = RUN_W'(1) << i;
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/abra_score_mem.sv
// Score map storage: one write port and one registered read port.
module abra_score_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_wen,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/abra_calc.sv
// Shared per-offset unit: extends the free run, checks fit and computes the byte score.
module abra_calc #(
    parameter int PW = 7
) (
    input  logic [PW-1:0]        i_pos,
    input  abra_pkg::t_calc_in   i_in,
    output abra_pkg::t_calc_res  o_res
);

    logic [abra_pkg::RUN_W-1:0] pos9;
    logic [abra_pkg::RUN_W-1:0] rl_next;
    logic [abra_pkg::RUN_W-1:0] low_bit;
    logic [abra_pkg::RUN_W-1:0] high_bit;
    logic [abra_pkg::RUN_W-1:0] al;
    logic                       aligned;

    always_comb begin
        pos9    = abra_pkg::RUN_W'(i_pos);
        rl_next = i_in.free ? i_in.rl_prev + abra_pkg::RUN_W'(1) : '0;
        // Offset zero is aligned to every power of two.
        low_bit = (pos9 == '0) ? abra_pkg::RUN_W'(256) : (pos9 & (~pos9 + abra_pkg::RUN_W'(1)));
        high_bit = abra_pkg::msb_pow2(rl_next);
        al       = (low_bit < high_bit) ? low_bit : high_bit;
        aligned  = ((pos9 & (abra_pkg::RUN_W'(i_in.align) - abra_pkg::RUN_W'(1))) == '0);

        o_res.rl_next = rl_next;
        o_res.fits    = aligned && (rl_next >= abra_pkg::RUN_W'(i_in.size));
        if (!i_in.free) begin
            o_res.score = '0;
        end else if (al[8]) begin
            o_res.score = 8'hFF;
        end else begin
            o_res.score = al[7:0];
        end
    end

endmodule

>>> hdl/aligned_byte_region_allocator.sv
// Top level of the aligned byte region allocator: sequencer, free map and stream ports.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------
//  s request | in        | i_s_tvalid / o_s_tready | op, request_size, request_align, off
//  m result  | out       | o_m_tvalid / i_m_tready | status, granted_offset
//  config    | in        | i_cfg_wen               | i_cfg_idx, i_cfg_data
//
// A reserve request first runs the offset search, which reads and then evaluates
// each score; if a place is found, the rescore runs one backward pass that writes
// each byte's score and one forward pass that reads and then writes each byte, all
// on the one score memory. Init runs only the rescore; invalid requests skip both.
// Reset clears the free map, so no memory clearing pass is needed.
// A finished result waits in the output register; the next request is taken
// while it waits, but the sequencer holds its own result until the port is free.
module aligned_byte_region_allocator #(
    parameter int REGION_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] op, [9:2] request_size, [17:10] request_align, [24:18] requested_offset
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] status, [8:2] granted_offset
    output logic [15:0] o_m_tdata,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    localparam int PW = $clog2(REGION_BYTES);
    localparam int GW = $clog2(REGION_BYTES + 1);
    localparam int RW = abra_pkg::RUN_W;
    localparam logic [PW-1:0] LAST   = PW'(REGION_BYTES - 1);
    localparam logic [RW-1:0] REGION = RW'(REGION_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_EV,
        S_RSC_BK,
        S_RSC_FW_RD,
        S_RSC_FW_WR,
        S_RESULT
    } t_state;

    t_state            r_state;
    logic [PW-1:0]     r_pos;
    logic [RW-1:0]     r_rl;
    logic [7:0]        r_best;
    logic              r_found;
    logic [GW-1:0]     r_grant;
    logic [1:0]        r_op;
    logic [7:0]        r_size;
    logic [7:0]        r_align;
    logic [6:0]        r_want;
    logic [1:0]        r_status;
    logic [REGION_BYTES-1:0] r_free;
    logic [7:0]        r_run_max;
    logic [6:0]        r_win_start;
    logic [7:0]        r_win_len;
    logic              r_m_valid;
    logic [1:0]        r_m_status;
    logic [6:0]        r_m_grant;

    // Request fields.
    logic [1:0]        in_op;
    logic [7:0]        in_size;
    logic [7:0]        in_align;
    logic [6:0]        in_want;
    logic              in_bad;
    logic [RW-1:0]     want9;
    logic              want_aligned;
    logic              accept;

    logic [RW-1:0]     pos9;
    logic [RW-1:0]     grant9;
    logic              in_grant;
    logic              in_win;
    logic              bk_free;
    logic              cur_free;
    logic [7:0]        rd_data;
    logic [7:0]        score_eff;
    logic              take;
    logic              n_found;
    logic [7:0]        fw_max;
    logic              mem_wen;
    logic [7:0]        mem_wdata;

    abra_pkg::t_calc_in  calc_in;
    abra_pkg::t_calc_res calc_res;

    assign in_op    = i_s_tdata[1:0];
    assign in_size  = i_s_tdata[9:2];
    assign in_align = i_s_tdata[17:10];
    assign in_want  = i_s_tdata[24:18];
    assign in_bad   = (in_op != abra_pkg::OP_BEST && in_op != abra_pkg::OP_AT)
                   || (RW'(in_size) >= REGION) || (in_align == 8'd0)
                   || ((in_align & (in_align - 8'd1)) != 8'd0);
    assign want9        = RW'(in_want);
    assign want_aligned = ((want9 & (RW'(in_align) - RW'(1))) == '0);

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    assign pos9     = RW'(r_pos);
    assign grant9   = RW'(r_grant);
    assign cur_free = r_free[r_pos];
    assign in_grant = (pos9 >= grant9) && (pos9 < grant9 + RW'(r_size));
    assign in_win   = (pos9 >= RW'(r_win_start))
                   && (pos9 < RW'(r_win_start) + RW'(r_win_len));
    assign bk_free  = (r_op == abra_pkg::OP_INIT) ? in_win : (cur_free && !in_grant);

    always_comb begin
        calc_in.rl_prev = r_rl;
        calc_in.free    = (r_state == S_RSC_BK) ? bk_free : cur_free;
        calc_in.size    = r_size;
        calc_in.align   = r_align;
    end

    abra_calc #(.PW(PW)) u_calc (
        .i_pos (r_pos),
        .i_in  (calc_in),
        .o_res (calc_res)
    );

    // A used byte always scores zero, so the free map also masks unwritten entries.
    assign score_eff = cur_free ? rd_data : 8'd0;
    assign take = calc_res.fits
               && ((r_op == abra_pkg::OP_BEST) ? (!r_found || score_eff <= r_best)
                                                : (pos9 == RW'(r_want)));
    assign n_found = r_found || take;
    assign fw_max  = !cur_free ? 8'd0 : ((rd_data > r_run_max) ? rd_data : r_run_max);

    assign mem_wen   = (r_state == S_RSC_BK) || (r_state == S_RSC_FW_WR);
    assign mem_wdata = (r_state == S_RSC_BK) ? calc_res.score : fw_max;

    abra_score_mem #(.DEPTH(REGION_BYTES), .AW(PW)) u_mem (
        .i_clk   (i_clk),
        .i_wen   (mem_wen),
        .i_waddr (r_pos),
        .i_wdata (mem_wdata),
        .i_raddr (r_pos),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_found     <= 1'b0;
            r_free      <= '0;
            r_win_start <= '0;
            r_win_len   <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    abra_pkg::REG_WIN_START: r_win_start <= i_cfg_data[6:0];
                    abra_pkg::REG_WIN_LEN:   r_win_len   <= i_cfg_data;
                    default: ;
                endcase
            end
            // In the result state the output register is reloaded instead.
            if (r_m_valid && i_m_tready && r_state != S_RESULT) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= in_op;
                        r_size  <= in_size;
                        r_align <= in_align;
                        r_want  <= in_want;
                        r_pos   <= LAST;
                        r_rl    <= '0;
                        r_found <= 1'b0;
                        r_best  <= '0;
                        r_grant <= '0;
                        if (in_op == abra_pkg::OP_INIT) begin
                            r_status <= abra_pkg::ST_OK;
                            r_state  <= S_RSC_BK;
                        end else if (in_bad) begin
                            r_status <= abra_pkg::ST_INVALID;
                            r_state  <= S_RESULT;
                        end else if (in_op == abra_pkg::OP_AT && want9 >= REGION) begin
                            // Only an empty request right at the region end fits here.
                            if (in_size == 8'd0 && want9 == REGION && want_aligned) begin
                                r_grant  <= GW'(want9);
                                r_status <= abra_pkg::ST_OK;
                                r_state  <= S_RSC_BK;
                            end else begin
                                r_status <= abra_pkg::ST_BUSY;
                                r_state  <= S_RESULT;
                            end
                        end else begin
                            r_status <= abra_pkg::ST_OK;
                            r_state  <= S_SRCH_RD;
                        end
                    end
                end
                S_SRCH_RD: begin
                    r_state <= S_SRCH_EV;
                end
                S_SRCH_EV: begin
                    // Scanning downward, an equal score replaces the best so the lowest offset wins.
                    r_rl    <= calc_res.rl_next;
                    r_found <= n_found;
                    if (take) begin
                        r_best  <= score_eff;
                        r_grant <= GW'(r_pos);
                    end
                    if (r_pos == '0) begin
                        if (n_found) begin
                            r_pos   <= LAST;
                            r_rl    <= '0;
                            r_state <= S_RSC_BK;
                        end else begin
                            r_status <= (r_op == abra_pkg::OP_BEST) ? abra_pkg::ST_NOSPACE
                                                                   : abra_pkg::ST_BUSY;
                            r_grant  <= '0;
                            r_state  <= S_RESULT;
                        end
                    end else begin
                        r_pos   <= r_pos - PW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_RSC_BK: begin
                    r_free[r_pos] <= bk_free;
                    r_rl          <= calc_res.rl_next;
                    if (r_pos == '0) begin
                        r_run_max <= '0;
                        r_state   <= S_RSC_FW_RD;
                    end else begin
                        r_pos <= r_pos - PW'(1);
                    end
                end
                S_RSC_FW_RD: begin
                    r_state <= S_RSC_FW_WR;
                end
                S_RSC_FW_WR: begin
                    r_run_max <= fw_max;
                    if (r_pos == LAST) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_RSC_FW_RD;
                    end
                end
                S_RESULT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_status;
                        r_m_grant  <= 7'(r_grant);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'd0, r_m_grant, r_m_status};

    `include "assert_macros.svh"

    `ABRA_ASSERT(a_accept_starts_work, i_clk, i_rst_n,
        accept |=> (r_state != S_IDLE), "request accepted but sequencer stayed idle")
    `ABRA_NEVER(a_error_zero_offset, i_clk, i_rst_n,
        r_m_valid && (r_m_status != abra_pkg::ST_OK) && (r_m_grant != 7'd0),
        "error result carries a nonzero offset")
    `ABRA_ASSERT(a_free_map_only_in_rescore, i_clk, i_rst_n,
        (i_rst_n && r_state != S_RSC_BK) |=> $stable(r_free),
        "free map changed outside the rescore pass")
    `ABRA_ASSERT(a_result_from_sequencer, i_clk, i_rst_n,
        $rose(r_m_valid) |-> ($past(r_state) == S_RESULT),
        "result appeared without a finished request")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the aligned byte region allocator with a score map predictor.
module tb;

    localparam int REGION = 128;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] status;
        logic [6:0] granted;
    } t_alloc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        i_cfg_wen = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [7:0]  i_cfg_data = '0;

    // Predictor state: one score per region byte plus the init window registers.
    logic [7:0] score_map [REGION];
    logic [6:0] win_start = '0;
    logic [7:0] win_len = '0;

    t_alloc_result pending_results [$];
    int errors = 0;
    int items_sent = 0;
    int windows_tried = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    aligned_byte_region_allocator #(.REGION_BYTES(REGION)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Every free byte first gets 1, then each free byte raises the bytes from it to the end
    // of its run to the largest aligned power of two that fits from there.
    function automatic void rescore_map();
        int run;
        int al;
        int v;
        for (int p = 0; p < REGION; p++) begin
            if (score_map[p] != 0) begin
                score_map[p] = 8'd1;
            end
        end
        for (int p = 0; p < REGION; p++) begin
            run = 0;
            while (p + run < REGION && score_map[p + run] != 0) begin
                run++;
            end
            if (run == 0) continue;
            al = 1;
            while ((p % (al * 2)) == 0 && al * 2 <= run) begin
                al = al * 2;
            end
            v = (al > 255) ? 255 : al;
            for (int k = p; k < p + run; k++) begin
                if (score_map[k] < v) begin
                    score_map[k] = v[7:0];
                end
            end
        end
    endfunction

    function automatic bit place_fits(int off, int size, int align);
        if ((off & (align - 1)) != 0) return 1'b0;
        if (off + size > REGION) return 1'b0;
        for (int k = 0; k < size; k++) begin
            if (score_map[off + k] == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_alloc_result predict_request(logic [1:0] op, logic [7:0] size,
                                                      logic [7:0] align, logic [6:0] want_off);
        t_alloc_result r;
        int best;
        int wend;
        int grant;
        bit found;
        r.status = abra_pkg::ST_OK;
        r.granted = '0;
        found = 1'b0;
        grant = 0;
        if (op == abra_pkg::OP_INIT) begin
            for (int p = 0; p < REGION; p++) begin
                score_map[p] = 8'd0;
            end
            wend = int'(win_start) + int'(win_len);
            if (wend > REGION) wend = REGION;
            for (int p = int'(win_start); p < wend; p++) begin
                score_map[p] = 8'd1;
            end
            rescore_map();
        end else if (op == OP_UNUSED || int'(size) >= REGION || align == 0 ||
                     (align & (align - 8'd1)) != 0) begin
            r.status = abra_pkg::ST_INVALID;
        end else begin
            if (op == abra_pkg::OP_BEST) begin
                best = 511;
                for (int p = 0; p < REGION; p++) begin
                    if (place_fits(p, int'(size), int'(align)) &&
                        int'(score_map[p]) < best) begin
                        best = int'(score_map[p]);
                        grant = p;
                        found = 1'b1;
                    end
                end
                if (!found) r.status = abra_pkg::ST_NOSPACE;
            end else if (place_fits(int'(want_off), int'(size), int'(align))) begin
                grant = int'(want_off);
                found = 1'b1;
            end else begin
                r.status = abra_pkg::ST_BUSY;
            end
            if (found) begin
                for (int k = 0; k < int'(size); k++) begin
                    score_map[grant + k] = 8'd0;
                end
                rescore_map();
                r.granted = grant[6:0];
            end
        end
        return r;
    endfunction

    // Result checker: each accepted result is matched against the oldest prediction.
    initial begin
        t_alloc_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got status %0d offset %0d",
                             $time, o_m_tdata[1:0], o_m_tdata[8:2]);
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tdata[1:0] !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, o_m_tdata[1:0]);
                    end
                    if (o_m_tdata[8:2] !== want.granted) begin
                        errors++;
                        $display("%0t: granted offset mismatch, expected %0d, got %0d",
                                 $time, want.granted, o_m_tdata[8:2]);
                    end
                end
            end
        end
    end

    // Result port ready: random stalls, or a long counted hold-off when requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_m_tready = 1'b0;
                hold_cycles--;
            end else begin
                i_m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 LIMIT_CYCLES, pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_request(input logic [1:0] op, input logic [7:0] size,
                                input logic [7:0] align, input logic [6:0] want_off);
        t_alloc_result r;
        while ($urandom_range(0, 99) < send_idle_pct) @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata = {7'b0, want_off, align, size, op};
        do @(posedge i_clk); while (!o_s_tready);
        r = predict_request(op, size, align, want_off);
        pending_results.push_back(r);
        status_seen[r.status]++;
        items_sent++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_wen = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_wen = 1'b0;
        if (idx == abra_pkg::REG_WIN_START) begin
            win_start = data[6:0];
        end else begin
            win_len = data;
        end
    endtask

    task automatic set_window(input logic [7:0] start_data, input logic [7:0] len_data);
        wait_idle();
        write_reg(abra_pkg::REG_WIN_START, start_data);
        write_reg(abra_pkg::REG_WIN_LEN, len_data);
        windows_tried++;
    endtask

    // Mostly well-formed reserves with small sizes and power-of-two alignment;
    // a tenth is raw noise over every field.
    task automatic send_random_request();
        int roll;
        int align_log;
        logic [7:0] size;
        logic [7:0] align;
        logic [6:0] off;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        end else if (roll < 13) begin
            send_request(abra_pkg::OP_INIT, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        end else begin
            align_log = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                    : $urandom_range(0, 3);
            align = 8'd1 << align_log;
            roll = $urandom_range(0, 9);
            if (roll < 7) size = 8'($urandom_range(1, 8));
            else if (roll < 9) size = 8'($urandom_range(0, 32));
            else size = 8'($urandom_range(0, 127));
            off = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 1) == 1) off = off & ~(align[6:0] - 7'd1);
            send_request($urandom_range(0, 1) ? abra_pkg::OP_AT : abra_pkg::OP_BEST,
                         size, align, off);
        end
    endtask

    task automatic test_directed();
        // Nothing is free after reset.
        send_request(abra_pkg::OP_INIT, 8'd0, 8'd0, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd1, 8'd1, 7'd0);
        // Zero size fits anywhere, even on used bytes.
        send_request(abra_pkg::OP_BEST, 8'd0, 8'd1, 7'd0);
        send_request(abra_pkg::OP_AT, 8'd0, 8'd1, 7'd127);
        // Start data with bit 7 set wraps to offset 0: whole region free.
        set_window(8'h80, 8'd128);
        send_request(abra_pkg::OP_INIT, 8'hFF, 8'hFF, 7'h7F);
        send_request(abra_pkg::OP_BEST, 8'd1, 8'd1, 7'd0);
        send_request(abra_pkg::OP_AT, 8'd1, 8'd1, 7'd0);
        send_request(abra_pkg::OP_AT, 8'd2, 8'd2, 7'd3);
        send_request(abra_pkg::OP_AT, 8'd4, 8'd2, 7'd126);
        send_request(OP_UNUSED, 8'd1, 8'd1, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd128, 8'd1, 7'd0);
        send_request(abra_pkg::OP_AT, 8'd255, 8'd128, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd1, 8'd0, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd1, 8'd3, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd1, 8'd255, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd64, 8'd128, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd127, 8'd1, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd1, 8'd1, 7'd0);
        send_request(abra_pkg::OP_INIT, 8'd0, 8'd0, 7'd0);
        send_request(abra_pkg::OP_AT, 8'd1, 8'd1, 7'd127);
        send_request(abra_pkg::OP_AT, 8'd64, 8'd64, 7'd64);
        send_request(abra_pkg::OP_BEST, 8'd63, 8'd64, 7'd0);
        // Window running past the region end is clipped.
        set_window(8'd100, 8'd200);
        send_request(abra_pkg::OP_INIT, 8'd0, 8'd0, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd28, 8'd4, 7'd0);
        // Last byte with zero length frees nothing.
        set_window(8'd127, 8'd0);
        send_request(abra_pkg::OP_INIT, 8'd0, 8'd0, 7'd0);
        send_request(abra_pkg::OP_BEST, 8'd0, 8'd128, 7'd0);
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
        int start_items;
        int roll;
        start_items = items_sent;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent - start_items < items) begin
            roll = $urandom_range(0, 5);
            if (roll == 0) set_window(8'd0, 8'd128);
            else if (roll == 1) set_window(8'hFF, 8'hFF);
            else set_window(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            send_request(abra_pkg::OP_INIT, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            repeat ($urandom_range(8, 24)) send_random_request();
        end
    endtask

    // The result port holds off while requests keep coming, so the input must stall.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_window(8'd0, 8'd128);
        send_request(abra_pkg::OP_INIT, 8'd0, 8'd0, 7'd0);
        hold_cycles = 3000;
        repeat (10) send_random_request();
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_traffic(120, 0, 0);
        test_random_traffic(120, 86, 0);
        test_backpressure();
        test_random_traffic(120, 0, 86);
        test_random_traffic(120, 25, 25);
        wait_idle();
        repeat (5 * REGION + 20) @(posedge i_clk);
        $display("Run covered %0d requests over %0d window settings, with idle and stall phases.",
                 items_sent, windows_tried);
        $display("Results: %0d ok, %0d invalid, %0d busy, %0d no space; %0d failures.",
                 status_seen[abra_pkg::ST_OK], status_seen[abra_pkg::ST_INVALID],
                 status_seen[abra_pkg::ST_BUSY], status_seen[abra_pkg::ST_NOSPACE], errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
